// ===== sv/nse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nse_pkg
// Shared constants and types for the nonzero span extractor.
// ----------------------------------------------------------------------------
package nse_pkg;

	localparam int LINE_BYTES  = 64;
	localparam int FRAME_LINES = 252;

	localparam int BYTE_W = 8;
	localparam int COL_W  = 6;
	localparam int LINE_W = 8;
	localparam int LEN_W  = 7;
	localparam int GAP_W  = 6;

	localparam logic [GAP_W-1:0]  GAP_RESET = GAP_W'(7);
	localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(LINE_BYTES - 1);
	localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(FRAME_LINES - 1);

	typedef struct packed {
		logic [LINE_W-1:0] line_index;
		logic [COL_W-1:0]  first_column;
		logic [LEN_W-1:0]  span_length;
	} span_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] pixel_byte;
	} step_t;

	typedef struct packed {
		logic  emit;
		span_t span;
	} span_res_t;

endpackage

// ===== sv/nse_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nse_if
// Valid/ready channels of the nonzero span extractor.
// ----------------------------------------------------------------------------
interface nse_pixel_if import nse_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] pixel_byte;

	modport source (output valid, output pixel_byte, input ready);
	modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface nse_span_if import nse_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [LINE_W-1:0] line_index;
	logic [COL_W-1:0]  first_column;
	logic [LEN_W-1:0]  span_length;

	modport source (output valid, output line_index, output first_column,
		output span_length, input ready);
	modport sink   (input valid, input line_index, input first_column,
		input span_length, output ready);
endinterface

interface nse_cfg_if import nse_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [GAP_W-1:0] gap_limit;

	modport source (output valid, output gap_limit, input ready);
	modport sink   (input valid, input gap_limit, output ready);
endinterface

// ===== sv/nse_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nse_core
// Column/line counters, open-span state and the per-byte emit decision.
// ----------------------------------------------------------------------------
module nse_core import nse_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  step_t            step,
	input  logic [GAP_W-1:0] gap_limit,
	output span_res_t        res
);

	logic [COL_W-1:0]  column_q;
	logic [LINE_W-1:0] line_q;
	logic              open_q;
	logic [COL_W-1:0]  start_q;
	logic [COL_W-1:0]  last_q;

	logic              lit;
	logic              at_end;
	logic [COL_W-1:0]  gap;
	logic              close_gap;
	logic              open_mid;
	logic [COL_W-1:0]  start_n;
	logic [COL_W-1:0]  last_n;

	always_comb begin
		lit       = step.pixel_byte != '0;
		at_end    = column_q == LAST_COL;
		gap       = column_q - last_q;
		close_gap = open_q && !lit && ({2'b00, gap} >= {2'b00, gap_limit});
		open_mid  = open_q;
		start_n   = start_q;
		last_n    = last_q;
		if (!open_q) begin
			if (lit) begin
				open_mid = 1'b1;
				start_n  = column_q;
				last_n   = column_q;
			end
		end else if (lit) begin
			last_n = column_q;
		end else if (close_gap) begin
			open_mid = 1'b0;
		end

		// flush an open span on the last byte of the line
		res.emit              = close_gap || (at_end && open_mid);
		res.span.line_index   = line_q;
		res.span.first_column = start_n;
		res.span.span_length  = {1'b0, last_n} - {1'b0, start_n} + LEN_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			line_q   <= '0;
			open_q   <= 1'b0;
			start_q  <= '0;
			last_q   <= '0;
		end else if (step.valid) begin
			start_q <= start_n;
			last_q  <= last_n;
			if (at_end) begin
				open_q   <= 1'b0;
				column_q <= '0;
				line_q   <= (line_q == LAST_LINE) ? '0 : line_q + LINE_W'(1);
			end else begin
				open_q   <= open_mid;
				column_q <= column_q + COL_W'(1);
			end
		end
	end

endmodule

// ===== sv/nonzero_span_extractor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonzero_span_extractor_top
// Finds spans of nonzero framebuffer bytes per line and reports each span;
// zero gaps shorter than gap_limit do not end a span.
//   channel    dir  fields                                    handshake
//   pixel_in   in   pixel_byte[7:0]                           valid/ready
//   span_out   out  line_index[7:0] first_column[5:0]
//                   span_length[6:0]                          valid/ready
//   cfg        in   gap_limit[5:0]                            valid/ready
//
// One byte per cycle while span_out is not stalled; the span a byte closes is
// decided from the input register and captured in the span register, from
// which it leaves on span_out.
// Reset clears counters, span state and both valid flags; gap_limit comes up 7.
// A stalled span register holds the input register; the input accepts a new
// beat whenever its register is empty or moving on in the same cycle.
// cfg is always ready.
// ----------------------------------------------------------------------------
module nonzero_span_extractor_top import nse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	nse_pixel_if.sink  pixel_in,
	nse_span_if.source span_out,
	nse_cfg_if.sink    cfg
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	span_t             span_q;
	logic [GAP_W-1:0]  gap_limit_q;
	logic              advance;
	step_t             step;
	span_res_t         res;

	assign advance         = !out_valid_q || span_out.ready;
	assign pixel_in.ready  = !valid_s1 || advance;
	assign cfg.ready       = 1'b1;
	assign step.valid      = valid_s1 && advance;
	assign step.pixel_byte = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_limit_q <= GAP_RESET;
		end else if (cfg.valid) begin
			gap_limit_q <= cfg.gap_limit;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pixel_in.ready) begin
			valid_s1 <= pixel_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel_in.ready) begin
			byte_s1 <= pixel_in.pixel_byte;
		end
	end

	nse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.gap_limit (gap_limit_q),
		.res       (res)
	);

	// span register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= step.valid && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			span_q <= res.span;
		end
	end

	assign span_out.valid        = out_valid_q;
	assign span_out.line_index   = span_q.line_index;
	assign span_out.first_column = span_q.first_column;
	assign span_out.span_length  = span_q.span_length;

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (span_q.span_length != '0) &&
			({1'b0, span_q.span_length} <= 8'(LINE_BYTES)))
		else $error("span length out of range");

	a_within_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((8'(span_q.first_column) + 8'(span_q.span_length))
			<= 8'(LINE_BYTES)))
		else $error("span runs past end of line");

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(step.valid && res.emit) |=> out_valid_q)
		else $error("emitted span not registered");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("stalled byte lost from input register");

endmodule
